### rtl/shpp_pkg.sv
`default_nettype none
package shpp_pkg;
   localparam int CommandLimitDefault = 1000;
   localparam int CmdW = 11;
   localparam int PosW = 16;
   localparam int IntW = 17;
   localparam int GainW = 16;
   localparam int CfgIdxW = 3;
   localparam int Windup = 50000;
   localparam int GainScale = 1000;
   localparam int StallTicks = 5;
   localparam int DwellMs = 200;
   localparam int MinTravel = 300;

   typedef enum logic [2:0] {
      CFG_GAIN_P = 3'd0, CFG_GAIN_I = 3'd1, CFG_GAIN_D = 3'd2,
      CFG_SPEED = 3'd3, CFG_STALL = 3'd4, CFG_TIMEOUT = 3'd5
   } cfg_index_type;

   typedef enum logic [1:0] {
      MODE_TICK = 2'd0, MODE_HOME = 2'd1, MODE_INIT = 2'd2, MODE_TARGET = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      PH_DISABLED = 3'd0, PH_START = 3'd1, PH_LEFT = 3'd2, PH_LDWELL = 3'd3,
      PH_RIGHT = 3'd4, PH_RDWELL = 3'd5, PH_DONE = 3'd6, PH_FAILED = 3'd7
   } phase_type;
endpackage
`default_nettype wire

### rtl/shpp_if.sv
`default_nettype none
interface shpp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic signed [15:0] encoder_position;
   logic signed [15:0] motor_current;
   logic [31:0] now_ms;
   logic signed [15:0] target_request;
   modport source (output valid, mode, encoder_position, motor_current, now_ms,
      target_request, input ready);
   modport sink (input valid, mode, encoder_position, motor_current, now_ms,
      target_request, output ready);
endinterface

interface shpp_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [10:0] motor_command;
   logic        speed_mode;
   logic [2:0]  phase;
   logic        homed;
   logic        failed;
   logic signed [15:0] left_limit;
   logic signed [15:0] right_limit;
   logic signed [15:0] center_position;
   logic signed [10:0] controller_value;
   modport source (output valid, motor_command, speed_mode, phase, homed, failed,
      left_limit, right_limit, center_position, controller_value, input ready);
   modport sink (input valid, motor_command, speed_mode, phase, homed, failed,
      left_limit, right_limit, center_position, controller_value, output ready);
endinterface

interface shpp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/steering_homing_position_pid.sv
// channel | dir | handshake        | payload
// req     | in  | valid/ready      | mode, encoder, current, now_ms, target
// rsp     | out | valid/ready      | command, mode, phase, flags, limits, pid
// csr     | in  | valid/ready      | index (3b), data (16b)
// rsp valid is set in S_OUT: non-tick modes go there straight from acceptance,
// a tick outside the done phase passes S_TGT1 first, and a done-phase tick also
// runs the target scaling and the PID terms one by one through a single 32x32
// multiplier; each division by a constant is a reciprocal multiply on that same
// multiplier. Synchronous active-high reset clears the control, config and
// status registers; the captured request and datapath registers are not reset.
// req is not ready while an item is in work or its result waits in rsp.
`default_nettype none
module steering_homing_position_pid
   import shpp_pkg::*;
#(
   parameter int COMMAND_LIMIT = CommandLimitDefault
) (
   input wire logic clock,
   input wire logic reset,
   shpp_req_if.sink req,
   shpp_rsp_if.source rsp,
   shpp_csr_if.sink csr
);
   localparam int CmdMaxI = (COMMAND_LIMIT > 1023) ? 1023 : COMMAND_LIMIT;
   localparam logic signed [CmdW-1:0] CmdMax = CmdW'(CmdMaxI);
   // floor(x / 125) = (x * Recip125) >> RecipShift for x < 2^28
   localparam logic signed [31:0] Recip125 = 32'sd274877907;
   localparam int RecipShift = 35;

   typedef enum logic [3:0] {
      S_IDLE, S_TGT1, S_TGT2, S_TGT3, S_MUL_P, S_MUL_I, S_DIV_I, S_DIV_I2,
      S_MUL_D, S_DIV_U, S_DIV_U2, S_OUT
   } state_type;

   state_type state_ff;

   logic signed [15:0] gain_p_ff, gain_i_ff, gain_d_ff, stall_ff, thr_ff;
   logic [9:0]  speed_ff;
   logic [14:0] timeout_ff, ltmo_ff;
   logic [2:0]  phase_ff;
   logic [31:0] pstart_ff;
   logic [2:0]  scount_ff;
   logic signed [IntW-1:0] integ_ff;
   logic signed [15:0] perr_ff;
   logic signed [CmdW-1:0] pid_ff, cmd_ff;
   logic signed [15:0] minp_ff, maxp_ff, midp_ff, tgt_ff;
   logic done_ff, fail_ff, smode_ff;

   logic signed [15:0] enc_ff, cur_ff;
   logic [31:0] now_ff;

   // shared datapath
   logic signed [47:0] acc_ff;
   logic signed [47:0] num_ff;
   logic signed [15:0] err_ff;
   logic signed [IntW-1:0] newint_ff;
   logic signed [31:0] mula_ff;
   logic signed [31:0] mulb_ff;
   logic signed [63:0] prod;
   logic dneg_ff;

   assign req.ready = (state_ff == S_IDLE) && !rsp.valid;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= '0; gain_i_ff <= '0; gain_d_ff <= '0;
         speed_ff <= 10'd100; stall_ff <= 16'sd200; timeout_ff <= 15'd5000;
      end else if (csr.valid) begin
         case (csr.index)
            CFG_GAIN_P:  gain_p_ff <= csr.data;
            CFG_GAIN_I:  gain_i_ff <= csr.data;
            CFG_GAIN_D:  gain_d_ff <= csr.data;
            CFG_SPEED:   speed_ff <= csr.data[9:0];
            CFG_STALL:   stall_ff <= csr.data;
            CFG_TIMEOUT: timeout_ff <= csr.data[14:0];
            default: ;
         endcase
      end
   end

   assign prod = 64'(mula_ff) * 64'(mulb_ff);

   // tick arithmetic, combinational from captured item
   logic [31:0] elapsed;
   logic [16:0] tlimit;
   logic signed [CmdW-1:0] spd;
   logic signed [16:0] travel;
   logic signed [16:0] midsum;
   assign elapsed = now_ff - pstart_ff;
   assign tlimit = (phase_ff == PH_RIGHT) ? {1'b0, ltmo_ff, 1'b0} : {2'b0, ltmo_ff};
   assign spd = ({1'b0, speed_ff} > 11'(CmdMaxI)) ? CmdMax : $signed({1'b0, speed_ff});
   assign travel = 17'(maxp_ff) - 17'(minp_ff);
   assign midsum = 17'(minp_ff) + 17'(maxp_ff);

   always_ff @(posedge clock) begin
      logic signed [18:0] e19;
      logic signed [18:0] i19;
      logic signed [16:0] d17;
      logic signed [10:0] norm;
      logic signed [17:0] cnt;
      logic [47:0] mag;
      logic signed [47:0] qs;
      logic [10:0] qu;
      logic signed [CmdW-1:0] res;
      if (reset) begin
         state_ff <= S_IDLE;
         rsp.valid <= 1'b0;
         phase_ff <= PH_DISABLED; pstart_ff <= '0; scount_ff <= '0;
         thr_ff <= '0; ltmo_ff <= '0; integ_ff <= '0; perr_ff <= '0;
         pid_ff <= '0; minp_ff <= 16'sd500; maxp_ff <= 16'sd3500;
         midp_ff <= 16'sd2000; done_ff <= 1'b0; fail_ff <= 1'b0;
         tgt_ff <= '0; cmd_ff <= '0; smode_ff <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
         case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               enc_ff <= req.encoder_position;
               cur_ff <= req.motor_current; now_ff <= req.now_ms;
               case (req.mode)
                  MODE_HOME: begin
                     if (phase_ff == PH_DISABLED || phase_ff == PH_FAILED) begin
                        phase_ff <= PH_START; done_ff <= 1'b0; fail_ff <= 1'b0;
                        pstart_ff <= req.now_ms; thr_ff <= stall_ff;
                        ltmo_ff <= timeout_ff; scount_ff <= '0; integ_ff <= '0;
                        perr_ff <= '0; pid_ff <= '0; smode_ff <= 1'b1;
                     end
                     state_ff <= S_OUT;
                  end
                  MODE_INIT: begin
                     phase_ff <= PH_DISABLED; done_ff <= 1'b0; fail_ff <= 1'b0;
                     integ_ff <= '0; perr_ff <= '0; pid_ff <= '0; tgt_ff <= '0;
                     minp_ff <= 16'sd500; maxp_ff <= 16'sd3500; midp_ff <= 16'sd2000;
                     state_ff <= S_OUT;
                  end
                  MODE_TARGET: begin
                     tgt_ff <= req.target_request;
                     state_ff <= S_OUT;
                  end
                  default: state_ff <= S_TGT1;
               endcase
            end
            S_TGT1: begin
               state_ff <= S_OUT;
               case (phase_ff)
                  PH_START: begin
                     cmd_ff <= '0; smode_ff <= 1'b1; phase_ff <= PH_LEFT;
                     pstart_ff <= now_ff; scount_ff <= '0;
                  end
                  PH_LEFT, PH_RIGHT: begin
                     cmd_ff <= (phase_ff == PH_LEFT) ? -spd : spd;
                     if (elapsed > 32'(tlimit)) begin
                        fail_ff <= 1'b1; phase_ff <= PH_FAILED;
                     end else if (cur_ff >= thr_ff) begin
                        if (scount_ff + 3'd1 >= 3'(StallTicks)) begin
                           if (phase_ff == PH_LEFT) minp_ff <= enc_ff;
                           else maxp_ff <= enc_ff;
                           phase_ff <= phase_ff + 3'd1;
                           pstart_ff <= now_ff; scount_ff <= '0;
                        end else scount_ff <= scount_ff + 3'd1;
                     end else scount_ff <= '0;
                  end
                  PH_LDWELL: begin
                     cmd_ff <= '0;
                     if (elapsed > 32'(DwellMs)) begin
                        phase_ff <= PH_RIGHT; pstart_ff <= now_ff; scount_ff <= '0;
                     end
                  end
                  PH_RDWELL: begin
                     cmd_ff <= '0;
                     if (elapsed > 32'(DwellMs)) begin
                        if (travel < 17'sd300) begin
                           fail_ff <= 1'b1; phase_ff <= PH_FAILED;
                        end else begin
                           midp_ff <= 16'((midsum + 17'(midsum[16] & midsum[0])) >>> 1);
                           integ_ff <= '0; perr_ff <= '0; pid_ff <= '0;
                           done_ff <= 1'b1; phase_ff <= PH_DONE; tgt_ff <= '0;
                        end
                     end
                  end
                  PH_DONE: begin
                     norm = (tgt_ff > 16'sd1000) ? 11'sd1000 :
                            (tgt_ff < -16'sd1000) ? -11'sd1000 : 11'(tgt_ff);
                     mula_ff <= 32'(norm) + 32'sd1000;
                     mulb_ff <= 32'(travel);
                     state_ff <= S_TGT2;
                  end
                  default: begin
                     smode_ff <= 1'b0; cmd_ff <= '0; integ_ff <= '0; pid_ff <= '0;
                  end
               endcase
            end
            S_TGT2: begin
               // travel is at least MinTravel here, so the product is not negative
               mula_ff <= 32'(prod[63:4]);
               mulb_ff <= Recip125;
               state_ff <= S_TGT3;
            end
            S_TGT3: begin
               cnt = 18'(minp_ff) + $signed({1'b0, prod[RecipShift+16:RecipShift]});
               if (cnt < 18'(minp_ff)) cnt = 18'(minp_ff);
               if (cnt > 18'(maxp_ff)) cnt = 18'(maxp_ff);
               e19 = 19'(cnt) - 19'(enc_ff);
               err_ff <= (e19 > 19'sd32767) ? 16'sh7fff :
                         (e19 < -19'sd32768) ? 16'sh8000 : 16'(e19);
               state_ff <= S_MUL_P;
            end
            S_MUL_P: begin
               i19 = 19'(integ_ff) + 19'(err_ff);
               newint_ff <= (i19 > 19'sd50000) ? 17'sd50000 :
                            (i19 < -19'sd50000) ? -17'sd50000 : 17'(i19);
               mula_ff <= 32'(gain_p_ff); mulb_ff <= 32'(err_ff);
               state_ff <= S_MUL_I;
            end
            S_MUL_I: begin
               acc_ff <= prod[47:0];
               mula_ff <= 32'(gain_i_ff); mulb_ff <= 32'(newint_ff);
               state_ff <= S_DIV_I;
            end
            S_DIV_I: begin
               qs = prod[47:0];
               mag = qs[47] ? 48'(-qs) : 48'(qs);
               dneg_ff <= qs[47];
               mula_ff <= 32'(mag[47:3]);
               mulb_ff <= Recip125;
               state_ff <= S_DIV_I2;
            end
            S_DIV_I2: begin
               qs = 48'(prod[63:RecipShift]);
               if (dneg_ff) qs = -qs;
               acc_ff <= acc_ff + qs;
               d17 = 17'(err_ff) - 17'(perr_ff);
               mula_ff <= 32'(gain_d_ff); mulb_ff <= 32'(d17);
               state_ff <= S_MUL_D;
            end
            S_MUL_D: begin
               num_ff <= acc_ff + prod[47:0];
               state_ff <= S_DIV_U;
            end
            S_DIV_U: begin
               qs = num_ff;
               mag = qs[47] ? 48'(-qs) : 48'(qs);
               dneg_ff <= qs[47];
               // large sums only need a quotient above the limit
               mula_ff <= (mag[47:20] != '0) ? 32'h0001_ffff : 32'(mag[19:3]);
               mulb_ff <= Recip125;
               state_ff <= S_DIV_U2;
            end
            S_DIV_U2: begin
               qu = prod[RecipShift+10:RecipShift];
               if (qu > 11'(CmdMaxI)) res = dneg_ff ? -CmdMax : CmdMax;
               else res = dneg_ff ? -$signed(qu) : $signed(qu);
               pid_ff <= res;
               cmd_ff <= res;
               integ_ff <= newint_ff; perr_ff <= err_ff; smode_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp.valid <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.motor_command = cmd_ff;
   assign rsp.speed_mode = smode_ff;
   assign rsp.phase = phase_ff;
   assign rsp.homed = done_ff;
   assign rsp.failed = fail_ff;
   assign rsp.left_limit = minp_ff;
   assign rsp.right_limit = maxp_ff;
   assign rsp.center_position = midp_ff;
   assign rsp.controller_value = pid_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (cmd_ff <= CmdMax && cmd_ff >= -CmdMax)) else $error("cmd range");
   a_integ_range: assert property (@(posedge clock) disable iff (reset)
      (integ_ff <= 17'sd50000 && integ_ff >= -17'sd50000)) else $error("integral");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && fail_ff)) else $error("flags");
endmodule
`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import shpp_pkg::*;

   typedef struct {
      mode_type mode;
      int enc;
      int cur;
      logic [31:0] now;
      int tgt;
      bit typed;
      phase_type ph;
      int cmd;
   } step_row_type;

   typedef struct {
      logic signed [10:0] cmd;
      logic spd;
      logic [2:0] ph;
      logic homed;
      logic failed;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic signed [15:0] center;
      logic signed [10:0] pid;
   } status_type;

   logic clock = 0;
   logic reset;
   shpp_req_if req ();
   shpp_rsp_if rsp ();
   shpp_csr_if csr ();

   steering_homing_position_pid dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   always #5 clock = ~clock;

   // controller copy
   int k_p, k_i, k_d, speed_cfg, stall_cfg, timeout_cfg;
   phase_type ph;
   logic [31:0] ph_start;
   int stalls, thr_l, tmo_l, integ, prev_err, pid_out;
   int lo_pos, hi_pos, mid_pos, target_q, cmd_q;
   bit homed_f, fail_f, spdmode_q;

   status_type status_q[$];
   step_row_type dir_rows[$];
   int errors = 0;
   logic [31:0] now_t;
   int burst_left = 0;

   function automatic longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic control_reset();
      k_p = 0; k_i = 0; k_d = 0;
      speed_cfg = 100; stall_cfg = 200; timeout_cfg = 5000;
      ph = PH_DISABLED; ph_start = 0; stalls = 0; thr_l = 0; tmo_l = 0;
      integ = 0; prev_err = 0; pid_out = 0;
      lo_pos = 500; hi_pos = 3500; mid_pos = 2000;
      homed_f = 0; fail_f = 0; target_q = 0; cmd_q = 0; spdmode_q = 0;
   endtask

   function automatic void control_tick(int enc, int cur, logic [31:0] now);
      logic [31:0] elapsed;
      logic [31:0] lim;
      int spd, norm, cnt, err, ig;
      longint u;
      elapsed = now - ph_start;
      spd = int'(clampl(speed_cfg, 0, 1000));
      case (ph)
         PH_START: begin
            cmd_q = 0; spdmode_q = 1; ph = PH_LEFT; ph_start = now; stalls = 0;
         end
         PH_LEFT, PH_RIGHT: begin
            lim = tmo_l;
            if (ph == PH_RIGHT) lim = lim * 2;
            cmd_q = (ph == PH_LEFT) ? -spd : spd;
            if (elapsed > lim) begin
               fail_f = 1; ph = PH_FAILED;
            end else if (cur >= thr_l) begin
               stalls++;
               if (stalls >= StallTicks) begin
                  if (ph == PH_LEFT) lo_pos = enc; else hi_pos = enc;
                  ph = phase_type'(ph + 1); ph_start = now; stalls = 0;
               end
            end else begin
               stalls = 0;
            end
         end
         PH_LDWELL: begin
            cmd_q = 0;
            if (elapsed > DwellMs) begin
               ph = PH_RIGHT; ph_start = now; stalls = 0;
            end
         end
         PH_RDWELL: begin
            cmd_q = 0;
            if (elapsed > DwellMs) begin
               if (hi_pos - lo_pos < MinTravel) begin
                  fail_f = 1; ph = PH_FAILED;
               end else begin
                  mid_pos = (lo_pos + hi_pos) / 2;
                  integ = 0; prev_err = 0; pid_out = 0;
                  homed_f = 1; ph = PH_DONE; target_q = 0;
               end
            end
         end
         PH_DONE: begin
            norm = int'(clampl(target_q, -1000, 1000));
            cnt = lo_pos + ((norm + 1000) * (hi_pos - lo_pos)) / 2000;
            if (cnt < lo_pos) cnt = lo_pos;
            if (cnt > hi_pos) cnt = hi_pos;
            err = int'(clampl(longint'(cnt) - enc, -32768, 32767));
            ig = int'(clampl(longint'(integ) + err, -Windup, Windup));
            u = longint'(k_p) * err + (longint'(k_i) * ig) / GainScale
               + longint'(k_d) * (longint'(err) - prev_err);
            pid_out = int'(clampl(u / GainScale, -1000, 1000));
            integ = ig; prev_err = err;
            spdmode_q = 1; cmd_q = pid_out;
         end
         default: begin
            spdmode_q = 0; cmd_q = 0; integ = 0; pid_out = 0;
         end
      endcase
   endfunction

   function automatic status_type control_step(step_row_type r);
      status_type s;
      case (r.mode)
         MODE_TICK: control_tick(r.enc, r.cur, r.now);
         MODE_HOME: if (ph == PH_DISABLED || ph == PH_FAILED) begin
            ph = PH_START; homed_f = 0; fail_f = 0; ph_start = r.now;
            thr_l = stall_cfg; tmo_l = timeout_cfg; stalls = 0;
            integ = 0; prev_err = 0; pid_out = 0; spdmode_q = 1;
         end
         MODE_INIT: begin
            ph = PH_DISABLED; homed_f = 0; fail_f = 0;
            integ = 0; prev_err = 0; pid_out = 0; target_q = 0;
            lo_pos = 500; hi_pos = 3500; mid_pos = 2000;
         end
         default: target_q = r.tgt;
      endcase
      s.cmd = 11'(cmd_q); s.spd = spdmode_q; s.ph = ph; s.homed = homed_f;
      s.failed = fail_f; s.left = 16'(lo_pos); s.right = 16'(hi_pos);
      s.center = 16'(mid_pos); s.pid = 11'(pid_out);
      return s;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("%0t: %s got %0d want %0d", $time, what, got, want);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      status_type w;
      if (!reset && rsp.valid && rsp.ready) begin
         if (status_q.size() == 0) begin
            report("item with nothing pending, phase", rsp.phase, -1);
         end else begin
            w = status_q.pop_front();
            if (rsp.motor_command !== w.cmd) report("motor_command", rsp.motor_command, w.cmd);
            if (rsp.speed_mode !== w.spd) report("speed_mode", rsp.speed_mode, w.spd);
            if (rsp.phase !== w.ph) report("phase", rsp.phase, w.ph);
            if (rsp.homed !== w.homed) report("homed", rsp.homed, w.homed);
            if (rsp.failed !== w.failed) report("failed", rsp.failed, w.failed);
            if (rsp.left_limit !== w.left) report("left_limit", rsp.left_limit, w.left);
            if (rsp.right_limit !== w.right) report("right_limit", rsp.right_limit, w.right);
            if (rsp.center_position !== w.center)
               report("center_position", rsp.center_position, w.center);
            if (rsp.controller_value !== w.pid)
               report("controller_value", rsp.controller_value, w.pid);
         end
      end
   end

   // receiver stall pattern
   int pat = 0, pat_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else begin
         if (pat_left == 0) begin
            pat = $urandom_range(0, 2);
            pat_left = $urandom_range(20, 300);
         end else begin
            pat_left--;
         end
         rsp.ready <= (pat == 0) ? 1'b1 : (pat == 1) ? 1'($urandom % 2)
            : ($urandom % 4 == 0);
      end
   end

   function automatic step_row_type row(mode_type m, int enc, int cur, logic [31:0] now,
                                        int tgt, bit typed, phase_type p, int cmd);
      step_row_type r;
      r.mode = m; r.enc = enc; r.cur = cur; r.now = now; r.tgt = tgt;
      r.typed = typed; r.ph = p; r.cmd = cmd;
      return r;
   endfunction

   task automatic send_item(step_row_type r);
      status_type s;
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
         if (gap > 0) begin
            req.valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req.valid <= 1;
      req.mode <= r.mode;
      req.encoder_position <= r.enc[15:0];
      req.motor_current <= r.cur[15:0];
      req.now_ms <= r.now;
      req.target_request <= r.tgt[15:0];
      do @(posedge clock); while (!req.ready);
      s = control_step(r);
      if (r.typed) begin
         s.ph = r.ph;
         s.cmd = 11'(r.cmd);
      end
      status_q.push_back(s);
   endtask

   task automatic csr_write(cfg_index_type idx, logic [15:0] data);
      csr.valid <= 1;
      csr.index <= idx;
      csr.data <= data;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 0;
      @(posedge clock);
      case (idx)
         CFG_GAIN_P: k_p = int'($signed(data));
         CFG_GAIN_I: k_i = int'($signed(data));
         CFG_GAIN_D: k_d = int'($signed(data));
         CFG_SPEED: speed_cfg = int'(data[9:0]);
         CFG_STALL: stall_cfg = int'($signed(data));
         CFG_TIMEOUT: timeout_cfg = int'(data[14:0]);
         default: ;
      endcase
   endtask

   task automatic drain();
      req.valid <= 0;
      burst_left = 0;
      wait (status_q.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic configure(int g, int s, int t);
      csr_write(CFG_GAIN_P, g == 2 ? 16'h7fff : g == 3 ? 16'h8000 : 16'($urandom));
      csr_write(CFG_GAIN_I, g == 2 ? 16'h7fff : g == 3 ? 16'h8000 : 16'($urandom));
      csr_write(CFG_GAIN_D, g == 2 ? 16'h7fff : g == 3 ? 16'h8000 : 16'($urandom));
      csr_write(CFG_SPEED, 16'(s));
      csr_write(CFG_STALL, g == 2 ? 16'h7fff : g == 3 ? 16'h8000
                : 16'($urandom_range(0, 3000)));
      csr_write(CFG_TIMEOUT, 16'(t));
   endtask

   function automatic step_row_type random_item();
      step_row_type r;
      int pick, spread;
      pick = $urandom_range(0, 99);
      r = row(MODE_TICK, 0, 0, now_t, $urandom, 0, PH_DISABLED, 0);
      if ((ph == PH_DISABLED || ph == PH_FAILED) && pick < 30) begin
         r.mode = MODE_HOME;
      end else if (pick < 3) begin
         r.mode = MODE_INIT;
      end else if (pick < 6) begin
         r.mode = MODE_HOME;
      end else if (pick < 12 || (ph == PH_DONE && pick < 20)) begin
         r.mode = MODE_TARGET;
         if ($urandom_range(0, 3) != 0) r.tgt = $urandom_range(0, 2400) - 1200;
      end else begin
         pick = $urandom_range(0, 99);
         now_t += pick < 80 ? 5 : pick < 97 ? $urandom_range(0, 400) : $urandom;
         r.now = now_t;
         spread = $urandom_range(0, 9) == 0 ? 32768 : 3000;
         r.enc = $urandom_range(0, 2 * spread - 1) - spread;
         if (ph == PH_DONE && $urandom_range(0, 1))
            r.enc = (lo_pos + hi_pos) / 2 + $urandom_range(0, 400) - 200;
         r.enc = int'(clampl(r.enc, -32768, 32767));
         if ((ph == PH_LEFT || ph == PH_RIGHT) && $urandom_range(0, 9) < 8)
            r.cur = int'(clampl(longint'(thr_l) + $urandom_range(0, 100), -32768, 32767));
         else
            r.cur = int'($signed(16'($urandom)));
      end
      return r;
   endfunction

   initial begin
      reset = 1;
      req.valid = 0; req.mode = MODE_TICK; req.encoder_position = 0;
      req.motor_current = 0; req.now_ms = 0; req.target_request = 0;
      csr.valid = 0; csr.index = CFG_GAIN_P; csr.data = 0;
      control_reset();
      repeat (4) @(posedge clock);
      reset <= 0;

      dir_rows.push_back(row(MODE_TICK, 0, 0, 0, 0, 1, PH_DISABLED, 0));
      dir_rows.push_back(row(MODE_TARGET, 0, 0, 0, 32767, 1, PH_DISABLED, 0));
      dir_rows.push_back(row(MODE_TARGET, 0, 0, 0, -32768, 1, PH_DISABLED, 0));
      dir_rows.push_back(row(MODE_HOME, 0, 0, 1000, 0, 1, PH_START, 0));
      dir_rows.push_back(row(MODE_HOME, 0, 0, 1001, 0, 1, PH_START, 0));
      dir_rows.push_back(row(MODE_INIT, 0, 0, 0, 0, 1, PH_DISABLED, 0));
      dir_rows.push_back(row(MODE_HOME, 0, 0, 1000, 0, 1, PH_START, 0));
      dir_rows.push_back(row(MODE_TICK, 0, 0, 1005, 0, 1, PH_LEFT, 0));
      for (int i = 0; i < 5; i++)
         dir_rows.push_back(row(MODE_TICK, -32768, 32767, 1010 + 5 * i, 0, 1,
                                i == 4 ? PH_LDWELL : PH_LEFT, -100));
      dir_rows.push_back(row(MODE_TICK, 0, -32768, 1100, 0, 1, PH_LDWELL, 0));
      dir_rows.push_back(row(MODE_TICK, 0, -32768, 1231, 0, 1, PH_RIGHT, 0));
      for (int i = 0; i < 5; i++)
         dir_rows.push_back(row(MODE_TICK, 32767, 200, 1236 + 5 * i, 0, 1,
                                i == 4 ? PH_RDWELL : PH_RIGHT, 100));
      dir_rows.push_back(row(MODE_TICK, 0, 0, 1500, 0, 1, PH_DONE, 0));
      dir_rows.push_back(row(MODE_TARGET, 0, 0, 0, 1000, 0, PH_DONE, 0));
      dir_rows.push_back(row(MODE_TICK, 0, 0, 1505, 0, 0, PH_DONE, 0));
      dir_rows.push_back(row(MODE_HOME, 0, 0, 1510, 0, 0, PH_DONE, 0));
      dir_rows.push_back(row(MODE_INIT, 0, 0, 0, 0, 1, PH_DISABLED, 0));
      dir_rows.push_back(row(MODE_HOME, 0, 0, 2000, 0, 1, PH_START, 0));
      dir_rows.push_back(row(MODE_TICK, 0, 0, 2005, 0, 1, PH_LEFT, 0));
      dir_rows.push_back(row(MODE_TICK, 0, 0, 9000, 0, 1, PH_FAILED, -100));
      foreach (dir_rows[i]) send_item(dir_rows[i]);
      drain();

      for (int p = 1; p <= 5; p++) begin
         case (p)
            1: begin
               csr_write(CFG_GAIN_P, 16'd1000); csr_write(CFG_GAIN_I, 16'd100);
               csr_write(CFG_GAIN_D, 16'd500); csr_write(CFG_SPEED, 16'd100);
               csr_write(CFG_STALL, 16'd200); csr_write(CFG_TIMEOUT, 16'd5000);
               csr_write(cfg_index_type'(3'd6), 16'hffff);
               csr_write(cfg_index_type'(3'd7), 16'h1234);
            end
            2: configure(2, 16'h03ff, 16'h7fff);
            3: configure(3, 16'd0, 16'd0);
            default: configure(4, $urandom, $urandom_range(300, 32767) | (p == 4 ? 16'h8000 : 0));
         endcase
         now_t = p == 2 ? 32'hffff_fe00 : $urandom;
         for (int n = 0; n < 330; n++) send_item(random_item());
         drain();
      end

      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire
